@@ hw/rtl/pds_pkg.sv @@
// Package with shared types and constants of the path delay statistics unit.
package pds_pkg;

	localparam int HistDepth = 16;
	localparam int HistIdxW = $clog2(HistDepth);
	localparam int HistFillW = $clog2(HistDepth + 1);

	localparam logic [31:0] RttNone = 32'hFFFF_FFFF;
	localparam logic signed [31:0] OwdNone = 32'sh7FFF_FFFF;
	localparam logic [39:0] Mask40 = 40'hFF_FFFF_FFFF;

	typedef enum logic [2:0] {
		KIND_RTT   = 3'd0,
		KIND_OWD   = 3'd1,
		KIND_ARR   = 3'd2,
		KIND_NACK  = 3'd3,
		KIND_ROUND = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MUL,
		ST_SCAN,
		ST_QD,
		ST_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
		logic mul;
		logic scan_start;
		logic scan_step;
		logic qd;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [2:0] kind;
		logic needs_mul;
		logic scan_last;
	} stat_t;

	localparam logic [0:0] RegAlpha = 1'd0;
	localparam logic [0:0] RegIdle = 1'd1;

endpackage

@@ hw/rtl/pds_ctrl.sv @@
// Controller state machine that sequences one item through the datapath.
module pds_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic out_busy,
	input  pds_pkg::stat_t stat,
	output pds_pkg::cmd_t cmd
);
	import pds_pkg::*;

	state_t state_q, state_d;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_EXEC;
			ST_EXEC: begin
				if (stat.needs_mul) state_d = ST_MUL;
				else if (stat.kind == KIND_ROUND) state_d = ST_SCAN;
				else state_d = ST_OUT;
			end
			ST_MUL: state_d = ST_OUT;
			ST_SCAN: if (stat.scan_last) state_d = ST_QD;
			ST_QD: state_d = ST_OUT;
			ST_OUT: if (!out_busy) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				cmd.scan_start = (stat.kind == KIND_ROUND);
			end
			ST_MUL: cmd.mul = 1'b1;
			ST_SCAN: cmd.scan_step = 1'b1;
			ST_QD: cmd.qd = 1'b1;
			ST_OUT: cmd.emit = !out_busy;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

endmodule

@@ hw/rtl/pds_datapath.sv @@
// Datapath holding the per-path delay state, histories and averaging logic.
module pds_datapath (
	input  logic clk,
	input  logic arst_n,
	input  pds_pkg::cmd_t cmd,
	output pds_pkg::stat_t stat,
	input  logic [2:0] in_kind,
	input  logic [31:0] in_rtt,
	input  logic signed [31:0] in_owd,
	input  logic [31:0] in_seg,
	input  logic [47:0] in_now,
	input  logic [15:0] alpha,
	input  logic [7:0] max_idle,
	output logic [31:0] win_rtt,
	output logic signed [31:0] win_owd,
	output logic signed [40:0] qd,
	output logic [39:0] gap,
	output logic act
);
	import pds_pkg::*;

	// Latched item.
	logic [2:0] kind_q;
	logic [31:0] rtt_q, seg_q;
	logic signed [31:0] owd_q;
	logic [47:0] now_q;

	logic [31:0] round_rtt_q, prior_rtt_q;
	logic signed [31:0] round_owd_q, prior_owd_q;
	logic [31:0] rtt_hist_q [HistDepth];
	logic signed [31:0] owd_hist_q [HistDepth];
	logic [HistFillW-1:0] rtt_fill_q, owd_fill_q;
	logic signed [39:0] owd_avg_q;
	logic owd_seed_q;
	logic signed [40:0] qd_q;
	logic [31:0] last_seg_q;
	logic [47:0] last_time_q;
	logic [39:0] gap_q;
	logic gap_seed_q, nack_q, data_q;
	logic [7:0] idle_q;
	logic [31:0] min_rtt_q;
	logic signed [31:0] min_owd_q;
	logic [HistIdxW-1:0] scan_q;
	logic owd_push_q;
	// EWMA operands: mul_sel_q picks owd (0) or gap (1) as target.
	logic mul_sel_q;
	logic signed [40:0] ew_old_q, ew_new_q;

	// Arrival decode.
	logic in_seq;
	logic [47:0] delta;
	logic [39:0] dq8;
	assign in_seq = (last_seg_q == seg_q - 32'd1);
	assign delta = now_q - last_time_q;
	assign dq8 = (|delta[47:32]) ? Mask40 : {delta[31:0], 8'd0};

	assign stat.kind = kind_q;
	assign stat.needs_mul = (kind_q == KIND_OWD && owd_seed_q)
		|| (kind_q == KIND_ARR && in_seq && gap_seed_q);
	assign stat.scan_last = (scan_q == HistIdxW'(HistDepth - 1));

	// EWMA: old*(65536-a) + new*a, floored by 2^16 (arith shift floors).
	logic signed [17:0] a_s, b_s;
	logic signed [58:0] ew_p_old, ew_p_new;
	logic signed [58:0] ew_sum;
	logic signed [42:0] ew_res;
	assign a_s = {2'b00, alpha};
	assign b_s = 18'sd65536 - a_s;
	assign ew_p_old = ew_old_q * b_s;
	assign ew_p_new = ew_new_q * a_s;
	assign ew_sum = ew_p_old + ew_p_new;
	assign ew_res = 43'(ew_sum >>> 16);

	// Push values at round end.
	logic [31:0] nxt_prior_rtt, push_rtt;
	logic signed [31:0] nxt_prior_owd;
	assign nxt_prior_rtt = (round_rtt_q != RttNone) ? round_rtt_q : prior_rtt_q;
	assign push_rtt = (nxt_prior_rtt == 32'd0) ? 32'd1 : nxt_prior_rtt;
	assign nxt_prior_owd = (round_owd_q != OwdNone) ? round_owd_q : prior_owd_q;

	logic scan_rtt_ok, scan_owd_ok;
	assign scan_rtt_ok = ({1'b0, scan_q} < rtt_fill_q);
	assign scan_owd_ok = ({1'b0, scan_q} < owd_fill_q);

	// Histories as shift lines, payload only.
	always_ff @(posedge clk) begin
		if (cmd.exec && kind_q == KIND_ROUND) begin
			for (int i = HistDepth - 1; i > 0; i--) rtt_hist_q[i] <= rtt_hist_q[i-1];
			rtt_hist_q[0] <= push_rtt;
			if (nxt_prior_owd != OwdNone) begin
				for (int i = HistDepth - 1; i > 0; i--) owd_hist_q[i] <= owd_hist_q[i-1];
				owd_hist_q[0] <= nxt_prior_owd;
			end
		end
		if (cmd.load) begin
			kind_q <= in_kind;
			rtt_q <= in_rtt;
			owd_q <= in_owd;
			seg_q <= in_seg;
			now_q <= in_now;
		end
		if (cmd.exec) begin
			mul_sel_q <= (kind_q == KIND_ARR);
			ew_old_q <= (kind_q == KIND_ARR) ? {1'b0, gap_q} : {owd_avg_q[39], owd_avg_q};
			ew_new_q <= (kind_q == KIND_ARR) ? {1'b0, dq8} : {owd_q[31], owd_q, 8'd0};
		end
		if (cmd.scan_start) begin
			min_rtt_q <= RttNone;
			min_owd_q <= OwdNone;
			scan_q <= '0;
		end
		if (cmd.scan_step) begin
			if (scan_rtt_ok && rtt_hist_q[scan_q] < min_rtt_q) min_rtt_q <= rtt_hist_q[scan_q];
			if (scan_owd_ok && owd_hist_q[scan_q] < min_owd_q) min_owd_q <= owd_hist_q[scan_q];
			scan_q <= scan_q + HistIdxW'(1);
		end
	end

	// Control state and scalar statistics.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_rtt_q <= RttNone;
			prior_rtt_q <= RttNone;
			round_owd_q <= OwdNone;
			prior_owd_q <= OwdNone;
			rtt_fill_q <= '0;
			owd_fill_q <= '0;
			owd_avg_q <= '0;
			owd_seed_q <= 1'b0;
			qd_q <= '0;
			last_seg_q <= '0;
			last_time_q <= '0;
			gap_q <= '0;
			gap_seed_q <= 1'b0;
			nack_q <= 1'b0;
			data_q <= 1'b0;
			idle_q <= '0;
			owd_push_q <= 1'b0;
			win_rtt <= '0;
			win_owd <= '0;
		end else begin
			if (cmd.exec) begin
				case (kind_q)
					KIND_RTT: if (rtt_q < round_rtt_q) round_rtt_q <= rtt_q;
					KIND_OWD: begin
						if (owd_q < round_owd_q) round_owd_q <= owd_q;
						if (!owd_seed_q) begin
							owd_avg_q <= {owd_q, 8'd0};
							owd_seed_q <= 1'b1;
						end
						data_q <= 1'b1;
					end
					KIND_ARR: begin
						if (in_seq || last_seg_q <= seg_q) begin
							last_seg_q <= seg_q;
							last_time_q <= now_q;
						end
						if (in_seq && !gap_seed_q) begin
							gap_q <= dq8;
							gap_seed_q <= 1'b1;
						end
					end
					KIND_NACK: nack_q <= 1'b1;
					KIND_ROUND: begin
						prior_rtt_q <= nxt_prior_rtt;
						round_rtt_q <= RttNone;
						if (rtt_fill_q != HistFillW'(HistDepth)) rtt_fill_q <= rtt_fill_q + 1'b1;
						prior_owd_q <= nxt_prior_owd;
						owd_push_q <= (nxt_prior_owd != OwdNone);
						if (nxt_prior_owd != OwdNone) begin
							round_owd_q <= OwdNone;
							if (owd_fill_q != HistFillW'(HistDepth))
								owd_fill_q <= owd_fill_q + 1'b1;
						end
						if (!data_q) begin
							if (idle_q != 8'hFF) idle_q <= idle_q + 8'd1;
						end else idle_q <= '0;
						data_q <= 1'b0;
					end
					default: ;
				endcase
			end
			if (cmd.mul) begin
				if (mul_sel_q) gap_q <= ew_res[39:0];
				else owd_avg_q <= ew_res[39:0];
			end
			if (cmd.qd) begin
				win_rtt <= min_rtt_q;
				win_owd <= (owd_fill_q == '0) ? 32'sd0 : min_owd_q;
				if (owd_push_q)
					qd_q <= {owd_avg_q[39], owd_avg_q} - {min_owd_q[31], min_owd_q, 8'd0};
				else qd_q <= '0;
			end
		end
	end

	assign qd = qd_q;
	assign gap = gap_q;
	assign act = nack_q && (idle_q < max_idle);

endmodule

@@ hw/rtl/path_delay_statistics_unit.sv @@
// An accepted item passes through EXEC, then MUL for averaging items or SCAN and QD for a
// round end, then OUT, which waits while the output register still holds an untaken result.
// One item at a time: a new item is accepted only after the last one has left OUT, and the
// history scan at a round end takes one entry per cycle.
// Results sit in an output register while the next item is accepted.
// Reset (arst_n, asynchronous) clears all statistics and loads register defaults.
// Top level of the path delay statistics unit.
module path_delay_statistics_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [143:0] s_axis_tdata, // rtt_ms, owd_ms, segment, now_ms
	input  logic [2:0] s_axis_tuser, // kind
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [151:0] m_axis_tdata, // min_rtt, min_owd, queue_delay_q8, gap_q8
	output logic m_axis_tuser, // active
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import pds_pkg::*;

	cmd_t cmd;
	stat_t stat;
	logic [15:0] alpha_q;
	logic [7:0] idle_lim_q;
	logic [31:0] w_rtt;
	logic signed [31:0] w_owd;
	logic signed [40:0] qd;
	logic [39:0] gap;
	logic act;
	logic out_busy;

	assign pready = 1'b1;
	assign out_busy = m_axis_tvalid && !m_axis_tready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= 16'd8192;
			idle_lim_q <= 8'd10;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == RegAlpha) alpha_q <= pwdata[15:0];
			else idle_lim_q <= pwdata[7:0];
		end
	end
	assign prdata = (paddr[2] == RegIdle) ? {24'd0, idle_lim_q} : {16'd0, alpha_q};

	pds_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.out_busy, .stat, .cmd
	);

	pds_datapath u_dp (
		.clk, .arst_n, .cmd, .stat,
		.in_kind(s_axis_tuser),
		.in_rtt(s_axis_tdata[31:0]),
		.in_owd(s_axis_tdata[63:32]),
		.in_seg(s_axis_tdata[95:64]),
		.in_now(s_axis_tdata[143:96]),
		.alpha(alpha_q), .max_idle(idle_lim_q),
		.win_rtt(w_rtt), .win_owd(w_owd), .qd, .gap, .act
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tvalid <= 1'b0;
		else if (cmd.emit) m_axis_tvalid <= 1'b1;
		else if (m_axis_tready) m_axis_tvalid <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			m_axis_tdata <= {7'd0, gap, qd, w_owd, w_rtt};
			m_axis_tuser <= act;
		end
	end

endmodule

@@ hw/rtl/pds_checker.sv @@
// Port-level checker for the path delay statistics unit, with its bind.
module pds_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [151:0] m_axis_tdata,
	input logic pready
);
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("item accepted twice");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[151:145] == 7'd0)
		else $error("padding set");
endmodule

bind path_delay_statistics_unit pds_checker u_chk (.*);

@@ test/tb_path_delay_statistics_unit.sv @@
// Self-checking testbench of the path delay statistics unit with a built-in behavioral predictor.
`timescale 1ns / 100ps

module tb_path_delay_statistics_unit;
	import pds_pkg::*;

	// One result item as the block reports it.
	typedef struct {
		logic [31:0] min_rtt;
		logic signed [31:0] min_owd;
		logic signed [40:0] qdelay;
		logic [39:0] gap;
		logic active;
	} stats_t;

	// Scoreboard: predicts the statistics and checks each result against the oldest one.
	class delay_scoreboard;
		logic [15:0] alpha;
		logic [7:0] idle_limit;
		logic [31:0] rnd_rtt, prev_rtt;
		logic [31:0] rtt_hist [HistDepth];
		int rtt_cnt;
		longint rnd_owd, prev_owd;
		longint owd_hist [HistDepth];
		int owd_cnt;
		longint owd_avg;
		bit owd_seeded;
		longint qdelay;
		logic [31:0] last_seg;
		logic [47:0] last_time;
		longint gap_avg;
		bit gap_seeded, nack_seen, data_seen;
		int idle_cnt;
		stats_t pending [$];
		int errors;

		function new();
			alpha = 16'd8192;
			idle_limit = 8'd10;
			rnd_rtt = RttNone;
			prev_rtt = RttNone;
			rtt_cnt = 0;
			rnd_owd = OwdNone;
			prev_owd = OwdNone;
			owd_cnt = 0;
			owd_avg = 0;
			owd_seeded = 0;
			qdelay = 0;
			last_seg = 0;
			last_time = 0;
			gap_avg = 0;
			gap_seeded = 0;
			nack_seen = 0;
			data_seen = 0;
			idle_cnt = 0;
			errors = 0;
		endfunction

		// Floor of the weighted mix of old value and new Q8 sample.
		function longint blend(longint old, longint smp);
			longint s;
			s = old * (65536 - longint'(alpha)) + smp * longint'(alpha);
			return s >>> 16;
		endfunction

		function void close_round();
			logic [31:0] r;
			longint m;
			if (rnd_rtt != RttNone) prev_rtt = rnd_rtt;
			r = (prev_rtt == 0) ? 32'd1 : prev_rtt;
			for (int i = HistDepth - 1; i > 0; i--) rtt_hist[i] = rtt_hist[i - 1];
			rtt_hist[0] = r;
			if (rtt_cnt < HistDepth) rtt_cnt++;
			rnd_rtt = RttNone;
			if (rnd_owd != OwdNone) prev_owd = rnd_owd;
			if (prev_owd != OwdNone) begin
				for (int i = HistDepth - 1; i > 0; i--) owd_hist[i] = owd_hist[i - 1];
				owd_hist[0] = prev_owd;
				if (owd_cnt < HistDepth) owd_cnt++;
				rnd_owd = OwdNone;
				m = OwdNone;
				for (int i = 0; i < owd_cnt; i++) if (owd_hist[i] < m) m = owd_hist[i];
				qdelay = owd_avg - m * 256;
			end else begin
				qdelay = 0;
			end
			if (!data_seen) begin
				if (idle_cnt < 255) idle_cnt++;
			end else begin
				idle_cnt = 0;
			end
			data_seen = 0;
		endfunction

		function void arrive(logic [31:0] seg, logic [47:0] now);
			logic [47:0] dt;
			longint dq;
			if (last_seg == seg - 32'd1) begin
				dt = now - last_time;
				dq = longint'(dt) << 8;
				if (dq > longint'(Mask40)) dq = longint'(Mask40);
				last_seg = seg;
				last_time = now;
				if (!gap_seeded) begin
					gap_avg = dq;
					gap_seeded = 1;
				end else begin
					gap_avg = blend(gap_avg, dq);
				end
			end else if (last_seg <= seg) begin
				last_seg = seg;
				last_time = now;
			end
		endfunction

		function void note_item(logic [2:0] kind, logic [143:0] d);
			stats_t e;
			longint o, m;
			case (kind)
				KIND_RTT: begin
					if (d[31:0] < rnd_rtt) rnd_rtt = d[31:0];
				end
				KIND_OWD: begin
					o = longint'($signed(d[63:32]));
					if (o < rnd_owd) rnd_owd = o;
					if (!owd_seeded) begin
						owd_avg = o * 256;
						owd_seeded = 1;
					end else begin
						owd_avg = blend(owd_avg, o * 256);
					end
					data_seen = 1;
				end
				KIND_ARR: arrive(d[95:64], d[143:96]);
				KIND_NACK: nack_seen = 1;
				KIND_ROUND: close_round();
				default: ;
			endcase
			e.min_rtt = 0;
			if (rtt_cnt > 0) begin
				e.min_rtt = RttNone;
				for (int i = 0; i < rtt_cnt; i++)
					if (rtt_hist[i] < e.min_rtt) e.min_rtt = rtt_hist[i];
			end
			m = 0;
			if (owd_cnt > 0) begin
				m = OwdNone;
				for (int i = 0; i < owd_cnt; i++) if (owd_hist[i] < m) m = owd_hist[i];
			end
			e.min_owd = m[31:0];
			e.qdelay = qdelay[40:0];
			e.gap = gap_avg[39:0];
			e.active = nack_seen && (idle_cnt < int'(idle_limit));
			pending.push_back(e);
		endfunction

		function void check_result(logic [151:0] d, logic act);
			stats_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result item: %h", d);
				return;
			end
			e = pending.pop_front();
			if (d[31:0] !== e.min_rtt || d[63:32] !== e.min_owd || d[104:64] !== e.qdelay
					|| d[144:105] !== e.gap || act !== e.active) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp rtt %h owd %h qd %h gap %h act %b, got %h act %b",
						e.min_rtt, e.min_owd, e.qdelay, e.gap, e.active, d, act);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [143:0] s_axis_tdata = '0;
	logic [2:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [151:0] m_axis_tdata;
	logic m_axis_tuser;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	path_delay_statistics_unit uut (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	delay_scoreboard board = new();
	int send_idle = 0, recv_stall = 0;
	int cycles = 0;
	bit timed_out = 0;

	// Sample accepted items on both sides at the rising edge.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (s_axis_tvalid && s_axis_tready) board.note_item(s_axis_tuser, s_axis_tdata);
		if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata, m_axis_tuser);
	end

	// Receiver backpressure, redrawn each falling edge.
	always @(negedge clk) begin
		if (arst_n) m_axis_tready <= ($urandom_range(99) >= recv_stall);
	end

	// Run limit.
	always @(posedge clk) begin
		if (cycles > 400000 && !timed_out) begin
			timed_out = 1;
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// The valid stays high into the next item unless the sender idles or the stream drains.
	task automatic send_item(input logic [2:0] kind, input logic [143:0] d);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= kind;
		s_axis_tdata <= d;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic send_fields(input logic [2:0] kind, input logic [31:0] rtt,
			input logic [31:0] owd, input logic [31:0] seg, input logic [47:0] now);
		send_item(kind, {now, seg, owd, rtt});
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
		psel <= 1;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		if (idx == RegAlpha) board.alpha = val[15:0];
		else board.idle_limit = val[7:0];
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	// One random item, biased toward realistic traffic with in-sequence arrivals.
	logic [31:0] seq_no = 0;
	logic [47:0] clock_ms = 0;
	task automatic random_item();
		int p;
		logic [2:0] k;
		logic [31:0] rtt, owd, seg;
		logic [47:0] now;
		p = $urandom_range(99);
		rtt = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(500);
		if (rtt == 32'hFFFF_FFFF) rtt = 32'hFFFF_FFFE;
		owd = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(300) - 100;
		if (owd == 32'h7FFF_FFFF) owd = 32'h7FFF_FFFE;
		seq_no = seq_no + 1;
		clock_ms = clock_ms + 48'($urandom_range(50));
		seg = seq_no;
		now = clock_ms;
		if ($urandom_range(19) == 0) seg = $urandom();
		if ($urandom_range(19) == 0) now = 48'({$urandom(), $urandom()});
		if (p < 20) k = KIND_RTT;
		else if (p < 40) k = KIND_OWD;
		else if (p < 70) k = KIND_ARR;
		else if (p < 75) k = KIND_NACK;
		else if (p < 95) k = KIND_ROUND;
		else k = 3'($urandom_range(5, 7));
		send_fields(k, rtt, owd, seg, now);
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// Directed: extremes and special cases.
		send_fields(KIND_ROUND, 0, 0, 0, 0);
		send_fields(KIND_NACK, 0, 0, 0, 0);
		send_fields(KIND_RTT, 32'hFFFF_FFFF, 0, 0, 0);
		send_fields(KIND_RTT, 32'hFFFF_FFFE, 0, 0, 0);
		send_fields(KIND_ROUND, 0, 0, 0, 0);
		send_fields(KIND_RTT, 0, 0, 0, 0);
		send_fields(KIND_OWD, 0, 32'h7FFF_FFFF, 0, 0);
		send_fields(KIND_OWD, 0, 32'h8000_0000, 0, 0);
		send_fields(KIND_OWD, 0, 32'h7FFF_FFFE, 0, 0);
		send_fields(KIND_ROUND, 0, 0, 0, 0);
		send_fields(KIND_ARR, 0, 0, 1, 48'd10);
		send_fields(KIND_ARR, 0, 0, 2, 48'hFFFF_FFFF_FFFF);
		send_fields(KIND_ARR, 0, 0, 3, 48'd5);
		send_fields(KIND_ARR, 0, 0, 1, 48'd7);
		send_fields(KIND_ARR, 0, 0, 9, 48'd8);
		send_fields(KIND_ARR, 0, 0, 32'hFFFF_FFFF, 48'd9);
		send_fields(KIND_ARR, 0, 0, 0, 48'd12);
		send_fields(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
		send_fields(3'd7, 0, 0, 0, 0);
		repeat (12) send_fields(KIND_ROUND, 0, 0, 0, 0);
		drain();

		// Random phases across register settings and idling modes.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 55; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 55; end
				default: begin send_idle = 7; recv_stall = 7; end
			endcase
			case (ph)
				1: begin write_reg(RegAlpha, 32'd1); write_reg(RegIdle, 32'd1); end
				2: begin write_reg(RegAlpha, 32'hFFFF); write_reg(RegIdle, 32'd255); end
				3: write_reg(RegAlpha, 32'd0);
				4: begin write_reg(RegAlpha, $urandom()); write_reg(RegIdle, 32'd3); end
				6: write_reg(RegIdle, $urandom_range(1, 255));
				default: ;
			endcase
			repeat (90) random_item();
			drain();
		end

		if (board.errors == 0 && board.pending.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ path_delay_statistics_unit.f @@
hw/rtl/pds_pkg.sv
hw/rtl/pds_ctrl.sv
hw/rtl/pds_datapath.sv
hw/rtl/path_delay_statistics_unit.sv
hw/rtl/pds_checker.sv
test/tb_path_delay_statistics_unit.sv
